FILE: design/vmu_pkg.sv
// ============================================================================
// Vector math unit package
// Shared types, operation codes and saturation helpers for the vector unit.
// ============================================================================
package vmu_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRACTION_BITS_DEF = 16;

    // Stages of one pipelined divider lane: one set-up stage and one per quotient bit.
    localparam int DIV_STAGES = 32;

    // Configuration register indexes.
    localparam logic CFG_USE_FOUR = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    typedef logic signed [31:0] t_q;
    typedef t_q [3:0] t_vec;

    typedef enum logic [3:0] {
        OP_ZERO      = 4'd0,
        OP_FILL      = 4'd1,
        OP_NEGATE    = 4'd2,
        OP_ADD       = 4'd3,
        OP_SUB       = 4'd4,
        OP_SCALE     = 4'd5,
        OP_CROSS     = 4'd6,
        OP_DOT       = 4'd7,
        OP_NORMSQ    = 4'd8,
        OP_NORM      = 4'd9,
        OP_NORMALIZE = 4'd10,
        OP_PROJECT   = 4'd11,
        OP_PLANE     = 4'd12,
        OP_REFLECT   = 4'd13,
        OP_LERP      = 4'd14
    } t_op;

    // Everything a word carries alongside the square root and divider units.
    typedef struct packed {
        t_op         op;
        t_vec        a;
        t_vec        b;
        t_vec        rs;     // finished vector result of the simple operations
        t_q          so;     // scalar result
        t_q          dot;    // saturated dot product (or squared norm of a)
        logic [30:0] nsqb;   // saturated squared norm of b
        t_q          krefl;  // reflection factor, twice the dot product
        logic        zero;   // squared norm at or below the threshold
    } t_side;

    localparam int SIDE_W = $bits(t_side);

    // Saturate a wide signed value to the 32-bit range.
    function automatic t_q sat_q(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // Apply sign and saturation to a divider lane result.
    function automatic t_q div_result(input logic ovf, input logic neg,
                                      input logic [30:0] mag);
        logic signed [31:0] m;
        m = $signed({1'b0, mag});
        if (ovf) begin
            return neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return neg ? -m : m;
    endfunction

endpackage

FILE: design/vmu_delay.sv
// ============================================================================
// Vector math unit delay line
// Shift line with a valid bit per stage that keeps words in step with a unit.
// ============================================================================
module vmu_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic             r_vld  [DEPTH];
    logic [WIDTH-1:0] r_data [DEPTH];

    // Valid bits are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Payload shifts without reset.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_valid = r_vld[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

FILE: design/vmu_sqrt.sv
// ============================================================================
// Vector math unit square root
// Pipelined integer square root of nsq * 2^FRACTION_BITS, one root bit a stage.
// ============================================================================
module vmu_sqrt #(
    parameter int FRACTION_BITS = vmu_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [30:0]                         i_nsq,
    output logic [(31+FRACTION_BITS+1)/2-1:0]   o_root
);

    localparam int SW  = 31 + FRACTION_BITS;
    localparam int RW  = (SW + 1) / 2;
    localparam int VW  = 2 * RW;
    localparam int RMW = RW + 2;

    logic [VW-1:0]  r_v   [RW];
    logic [RMW-1:0] r_rem [RW];
    logic [RW-1:0]  r_res [RW];

    logic [VW-1:0]  s_v   [RW];
    logic [RMW-1:0] s_rem [RW];
    logic [RW-1:0]  s_res [RW];
    logic [RMW-1:0] t_rem [RW];
    logic [RMW-1:0] trial [RW];
    logic           ge    [RW];
    logic [VW-1:0]  n_v   [RW];
    logic [RMW-1:0] n_rem [RW];
    logic [RW-1:0]  n_res [RW];

    // Stage inputs: the radicand enters stage zero.
    always_comb begin
        s_v[0]   = VW'({i_nsq, {FRACTION_BITS{1'b0}}});
        s_rem[0] = '0;
        s_res[0] = '0;
        for (int k = 1; k < RW; k++) begin
            s_v[k]   = r_v[k-1];
            s_rem[k] = r_rem[k-1];
            s_res[k] = r_res[k-1];
        end
    end

    // Each stage brings down two radicand bits and decides one root bit.
    always_comb begin
        for (int k = 0; k < RW; k++) begin
            t_rem[k] = {s_rem[k][RMW-3:0], s_v[k][VW-1 -: 2]};
            trial[k] = {s_res[k], 2'b01};
            ge[k]    = (t_rem[k] >= trial[k]);
            n_rem[k] = ge[k] ? (t_rem[k] - trial[k]) : t_rem[k];
            n_res[k] = {s_res[k][RW-2:0], ge[k]};
            n_v[k]   = s_v[k] << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_v[k]   <= n_v[k];
                r_rem[k] <= n_rem[k];
                r_res[k] <= n_res[k];
            end
        end
    end

    assign o_root = r_res[RW-1];

endmodule

FILE: design/vmu_div.sv
// ============================================================================
// Vector math unit divider lane
// Pipelined restoring division of num * 2^FRACTION_BITS by a positive divisor.
// ============================================================================
module vmu_div #(
    parameter int FRACTION_BITS = vmu_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_num,
    input  logic [30:0]        i_den,
    output logic               o_ovf,
    output logic               o_neg,
    output logic [30:0]        o_mag
);

    import vmu_pkg::*;

    localparam int NW = 32 + FRACTION_BITS;
    localparam int HW = NW - 31;

    logic [31:0]   mag;
    logic [NW-1:0] num_mag;
    logic [HW-1:0] hi;

    logic [30:0] r_rem [DIV_STAGES];
    logic [30:0] r_lo  [DIV_STAGES];
    logic [30:0] r_q   [DIV_STAGES];
    logic [30:0] r_den [DIV_STAGES];
    logic        r_ovf [DIV_STAGES];
    logic        r_neg [DIV_STAGES];

    logic [30:0] n_rem [DIV_STAGES];
    logic [30:0] n_lo  [DIV_STAGES];
    logic [30:0] n_q   [DIV_STAGES];
    logic [30:0] n_den [DIV_STAGES];
    logic        n_ovf [DIV_STAGES];
    logic        n_neg [DIV_STAGES];
    logic [31:0] t_rem [DIV_STAGES];
    logic        ge    [DIV_STAGES];

    always_comb begin
        // Set-up: magnitude, overflow test and the high part of the dividend.
        mag     = i_num[31] ? 32'(-i_num) : 32'(i_num);
        num_mag = {mag, {FRACTION_BITS{1'b0}}};
        hi      = num_mag[NW-1:31];
        n_rem[0] = 31'(hi);
        n_lo[0]  = num_mag[30:0];
        n_q[0]   = '0;
        n_den[0] = i_den;
        n_ovf[0] = (31'(hi) >= i_den);
        n_neg[0] = i_num[31];
        t_rem[0] = '0;
        ge[0]    = 1'b0;

        // One quotient bit a stage.
        for (int k = 1; k < DIV_STAGES; k++) begin
            t_rem[k] = {r_rem[k-1], r_lo[k-1][30]};
            ge[k]    = (t_rem[k] >= {1'b0, r_den[k-1]});
            n_rem[k] = ge[k] ? 31'(t_rem[k] - {1'b0, r_den[k-1]}) : t_rem[k][30:0];
            n_lo[k]  = r_lo[k-1] << 1;
            n_q[k]   = {r_q[k-1][29:0], ge[k]};
            n_den[k] = r_den[k-1];
            n_ovf[k] = r_ovf[k-1];
            n_neg[k] = r_neg[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_lo[k]  <= n_lo[k];
                r_q[k]   <= n_q[k];
                r_den[k] <= n_den[k];
                r_ovf[k] <= n_ovf[k];
                r_neg[k] <= n_neg[k];
            end
        end
    end

    assign o_ovf = r_ovf[DIV_STAGES-1];
    assign o_neg = r_neg[DIV_STAGES-1];
    assign o_mag = r_q[DIV_STAGES-1];

endmodule

FILE: design/vmu_front.sv
// ============================================================================
// Vector math unit front end
// Operand capture, eight multipliers and the sums that finish simple operations.
// ============================================================================
module vmu_front #(
    parameter int FRACTION_BITS = vmu_pkg::FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic                i_use_four,
    input  logic [15:0]         i_threshold,
    input  logic [3:0]          i_operation,
    input  logic signed [31:0]  i_a_x,
    input  logic signed [31:0]  i_a_y,
    input  logic signed [31:0]  i_a_z,
    input  logic signed [31:0]  i_a_w,
    input  logic signed [31:0]  i_b_x,
    input  logic signed [31:0]  i_b_y,
    input  logic signed [31:0]  i_b_z,
    input  logic signed [31:0]  i_b_w,
    input  logic signed [31:0]  i_scalar_in,
    output logic                o_valid,
    output vmu_pkg::t_side      o_side
);

    import vmu_pkg::*;

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRACTION_BITS;

    // Stage 1 registers.
    logic r1_valid;
    t_op  r1_op;
    t_vec r1_a;
    t_vec r1_b;
    t_q   r1_s;
    t_q   r1_alpha;

    // Stage 2 registers.
    logic               r2_valid;
    t_op                r2_op;
    t_vec               r2_a;
    t_vec               r2_b;
    t_q                 r2_s;
    logic signed [63:0] r2_m [8];

    // Stage 3 registers.
    logic               r3_valid;
    t_op                r3_op;
    t_vec               r3_a;
    t_vec               r3_b;
    t_q                 r3_s;
    logic signed [63:0] r3_v [4];
    logic signed [63:0] r3_p [4];

    // Stage 4 registers.
    logic  r4_valid;
    t_side r4_side;

    t_q [7:0]           pp;
    t_q [7:0]           qq;
    logic signed [63:0] n2_m [8];
    logic signed [63:0] q3   [8];
    logic signed [63:0] n3_v [4];
    logic signed [63:0] n3_p [4];
    t_side              n4_side;
    t_q                 sum0;
    t_q                 sum1;

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // Stage 1: capture operands; w is dropped in three-component mode.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op    <= t_op'(i_operation);
            r1_a     <= {i_use_four ? i_a_w : 32'sd0, i_a_z, i_a_y, i_a_x};
            r1_b     <= {i_use_four ? i_b_w : 32'sd0, i_b_z, i_b_y, i_b_x};
            r1_s     <= i_scalar_in;
            r1_alpha <= sat_q(ONE - 64'(i_scalar_in));
        end
    end

    // Multiplier operand selection by operation.
    always_comb begin
        pp = '0;
        qq = '0;
        case (r1_op)
            OP_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    pp[i] = r1_a[i];
                    qq[i] = r1_s;
                end
            end
            OP_CROSS: begin
                pp[0] = r1_a[1]; qq[0] = r1_b[2];
                pp[4] = r1_a[2]; qq[4] = r1_b[1];
                pp[1] = r1_a[2]; qq[1] = r1_b[0];
                pp[5] = r1_a[0]; qq[5] = r1_b[2];
                pp[2] = r1_a[0]; qq[2] = r1_b[1];
                pp[6] = r1_a[1]; qq[6] = r1_b[0];
            end
            OP_DOT, OP_REFLECT: begin
                for (int i = 0; i < 4; i++) begin
                    pp[i] = r1_a[i];
                    qq[i] = r1_b[i];
                end
            end
            OP_NORMSQ, OP_NORM, OP_NORMALIZE: begin
                for (int i = 0; i < 4; i++) begin
                    pp[i] = r1_a[i];
                    qq[i] = r1_a[i];
                end
            end
            OP_PROJECT, OP_PLANE: begin
                for (int i = 0; i < 4; i++) begin
                    pp[i]   = r1_a[i];
                    qq[i]   = r1_b[i];
                    pp[4+i] = r1_b[i];
                    qq[4+i] = r1_b[i];
                end
            end
            OP_LERP: begin
                for (int i = 0; i < 4; i++) begin
                    pp[i]   = r1_alpha;
                    qq[i]   = r1_a[i];
                    pp[4+i] = r1_s;
                    qq[4+i] = r1_b[i];
                end
            end
            default: begin
                pp = '0;
                qq = '0;
            end
        endcase
        for (int k = 0; k < 8; k++) begin
            n2_m[k] = $signed(pp[k]) * $signed(qq[k]);
        end
    end

    // Stage 2: full products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_op <= r1_op;
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_s  <= r1_s;
            for (int k = 0; k < 8; k++) begin
                r2_m[k] <= n2_m[k];
            end
        end
    end

    // Fixed-point scaling, per-component combination and pair sums.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            q3[k] = r2_m[k] >>> FRACTION_BITS;
        end
        for (int i = 0; i < 4; i++) begin
            case (r2_op)
                OP_SCALE: n3_v[i] = q3[i];
                OP_CROSS: n3_v[i] = q3[i] - q3[4+i];
                OP_LERP:  n3_v[i] = q3[i] + q3[4+i];
                default:  n3_v[i] = '0;
            endcase
        end
        n3_p[0] = q3[0] + q3[1];
        n3_p[1] = q3[2] + q3[3];
        n3_p[2] = q3[4] + q3[5];
        n3_p[3] = q3[6] + q3[7];
    end

    // Stage 3.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_op <= r2_op;
            r3_a  <= r2_a;
            r3_b  <= r2_b;
            r3_s  <= r2_s;
            for (int i = 0; i < 4; i++) begin
                r3_v[i] <= n3_v[i];
                r3_p[i] <= n3_p[i];
            end
        end
    end

    // Final sums, threshold test and simple vector results.
    always_comb begin
        sum0 = sat_q(r3_p[0] + r3_p[1]);
        sum1 = sat_q(r3_p[2] + r3_p[3]);
        n4_side.op    = r3_op;
        n4_side.a     = r3_a;
        n4_side.b     = r3_b;
        n4_side.dot   = sum0;
        n4_side.nsqb  = sum1[30:0];
        n4_side.krefl = sat_q(64'(sum0) <<< 1);
        if (r3_op == OP_NORMALIZE) begin
            n4_side.zero = ($signed(sum0) <= $signed({16'd0, i_threshold}));
        end else begin
            n4_side.zero = ($signed(sum1) <= $signed({16'd0, i_threshold}));
        end
        case (r3_op)
            OP_DOT, OP_NORMSQ: n4_side.so = sum0;
            default:           n4_side.so = '0;
        endcase
        for (int i = 0; i < 4; i++) begin
            case (r3_op)
                OP_FILL:   n4_side.rs[i] = r3_s;
                OP_NEGATE: n4_side.rs[i] = sat_q(-64'(r3_a[i]));
                OP_ADD:    n4_side.rs[i] = sat_q(64'(r3_a[i]) + 64'(r3_b[i]));
                OP_SUB:    n4_side.rs[i] = sat_q(64'(r3_a[i]) - 64'(r3_b[i]));
                OP_SCALE, OP_CROSS, OP_LERP: n4_side.rs[i] = sat_q(r3_v[i]);
                default:   n4_side.rs[i] = '0;
            endcase
        end
        if (!i_use_four) begin
            n4_side.rs[3] = '0;
        end
    end

    // Stage 4.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_side <= n4_side;
        end
    end

    assign o_valid = r4_valid;
    assign o_side  = r4_side;

endmodule

FILE: design/vector_math_unit_core.sv
// Every word passes through the front end, the square root and divider
// pipelines and the back stages on its way from input word to result word.
// Throughput: one word per cycle; the whole pipeline holds while a finished
// result waits. Reset is synchronous, active low; it clears all valid bits and
// sets the registers to three components and a threshold of one.
// ============================================================================
// Vector math unit core
// Fixed-point 3D/4D vector operations in a fully pipelined datapath.
// ============================================================================
module vector_math_unit_core #(
    parameter int FRACTION_BITS = vmu_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_operation,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_a_w,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_b_w,
    input  logic signed [31:0] i_scalar_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_r_x,
    output logic signed [31:0] o_r_y,
    output logic signed [31:0] o_r_z,
    output logic signed [31:0] o_r_w,
    output logic signed [31:0] o_scalar_out
);

    import vmu_pkg::*;

    localparam int RW = (31 + FRACTION_BITS + 1) / 2;

    logic        en;
    logic        r_use_four;
    logic [15:0] r_threshold;

    logic        f_valid;
    t_side       f_side;
    logic [RW-1:0] sq_root;
    logic        da_valid;
    t_side       da_side;
    t_side       sb_in;
    logic        db_valid;
    t_side       db_side;

    t_q [3:0]    dv_num;
    logic [30:0] dv_den [4];
    logic        dv_ovf [4];
    logic        dv_neg [4];
    logic [30:0] dv_mag [4];

    logic               r_d_valid;
    t_side              r_d_side;
    t_vec               r_d_q;
    logic               r_m_valid;
    t_side              r_m_side;
    t_vec               r_m_q;
    logic signed [63:0] r_m_p [4];
    logic               r_o_valid;
    t_vec               r_o_r;
    t_q                 r_o_so;

    t_q                 kk;
    logic signed [63:0] n_m_p [4];
    t_vec               n_o_r;
    t_q                 proj  [4];

    // The pipeline advances unless a result is waiting at the output.
    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_four  <= 1'b0;
            r_threshold <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_USE_FOUR:  r_use_four  <= i_cfg_data[0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default:       r_use_four  <= r_use_four;
            endcase
        end
    end

    // Multiply and sum stages.
    vmu_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_use_four  (r_use_four),
        .i_threshold (r_threshold),
        .i_operation (i_operation),
        .i_a_x       (i_a_x),
        .i_a_y       (i_a_y),
        .i_a_z       (i_a_z),
        .i_a_w       (i_a_w),
        .i_b_x       (i_b_x),
        .i_b_y       (i_b_y),
        .i_b_z       (i_b_z),
        .i_b_w       (i_b_w),
        .i_scalar_in (i_scalar_in),
        .o_valid     (f_valid),
        .o_side      (f_side)
    );

    // Square root of the squared norm of a, with the word alongside.
    vmu_sqrt #(.FRACTION_BITS(FRACTION_BITS)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_nsq  (f_side.dot[30:0]),
        .o_root (sq_root)
    );

    vmu_delay #(.WIDTH(SIDE_W), .DEPTH(RW)) u_delay_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_data  (f_side),
        .o_valid (da_valid),
        .o_data  (da_side)
    );

    // Divider operands: the components of a over the norm, or the dot product
    // over the squared norm of b in lane zero.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            dv_num[i] = da_side.a[i];
            dv_den[i] = 31'(sq_root);
        end
        if (da_side.op != OP_NORMALIZE) begin
            dv_num[0] = da_side.dot;
            dv_den[0] = da_side.nsqb;
        end
        sb_in = da_side;
        if (da_side.op == OP_NORM) begin
            sb_in.so = 32'(sq_root);
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_div
        vmu_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (dv_num[g]),
            .i_den (dv_den[g]),
            .o_ovf (dv_ovf[g]),
            .o_neg (dv_neg[g]),
            .o_mag (dv_mag[g])
        );
    end

    vmu_delay #(.WIDTH(SIDE_W), .DEPTH(DIV_STAGES)) u_delay_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (da_valid),
        .i_data  (sb_in),
        .o_valid (db_valid),
        .o_data  (db_side)
    );

    // Valid bits of the back stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= db_valid;
            r_m_valid <= r_d_valid;
            r_o_valid <= r_m_valid;
        end
    end

    // Sign and saturation of the quotients.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_side <= db_side;
            for (int i = 0; i < 4; i++) begin
                r_d_q[i] <= div_result(dv_ovf[i], dv_neg[i], dv_mag[i]);
            end
        end
    end

    // Projection and reflection products of b with the factor.
    always_comb begin
        kk = (r_d_side.op == OP_REFLECT) ? r_d_side.krefl : r_d_q[0];
        for (int i = 0; i < 4; i++) begin
            n_m_p[i] = $signed(r_d_side.b[i]) * $signed(kk);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_side <= r_d_side;
            r_m_q    <= r_d_q;
            for (int i = 0; i < 4; i++) begin
                r_m_p[i] <= n_m_p[i];
            end
        end
    end

    // Final result selection.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            proj[i] = sat_q(r_m_p[i] >>> FRACTION_BITS);
            case (r_m_side.op)
                OP_NORMALIZE: n_o_r[i] = r_m_side.zero ? 32'sd0 : r_m_q[i];
                OP_PROJECT:   n_o_r[i] = r_m_side.zero ? 32'sd0 : proj[i];
                OP_PLANE: begin
                    n_o_r[i] = r_m_side.zero ? r_m_side.a[i]
                        : sat_q(64'(r_m_side.a[i]) - 64'(proj[i]));
                end
                OP_REFLECT:   n_o_r[i] = sat_q(64'(r_m_side.a[i]) - 64'(proj[i]));
                default:      n_o_r[i] = r_m_side.rs[i];
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_r  <= n_o_r;
            r_o_so <= r_m_side.so;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_r_x        = r_o_r[0];
    assign o_r_y        = r_o_r[1];
    assign o_r_z        = r_o_r[2];
    assign o_r_w        = r_o_r[3];
    assign o_scalar_out = r_o_so;

endmodule

FILE: bench/tb_vector_math_unit_core.sv
`timescale 1ns / 1ps
// ============================================================================
// Vector math unit core testbench
// Drives operation words with random idling on both channels, predicts each
// result from its own fixed-point model and compares every field in order.
// ============================================================================
module tb_vector_math_unit_core;
    import vmu_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = 63;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] ax, ay, az, aw, bx, by, bz, bw, s;
    } t_word;

    typedef struct packed {
        logic signed [31:0] rx, ry, rz, rw, so;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [3:0] i_operation = '0;
    logic signed [31:0] i_a_x = 0, i_a_y = 0, i_a_z = 0, i_a_w = 0;
    logic signed [31:0] i_b_x = 0, i_b_y = 0, i_b_z = 0, i_b_w = 0;
    logic signed [31:0] i_scalar_in = 0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [31:0] o_r_x, o_r_y, o_r_z, o_r_w, o_scalar_out;

    // Predictor copy of the registers.
    logic        four_comp = 1'b0;
    logic [15:0] zero_thr = 16'd1;

    t_res  expected_q[$];
    int    fail_count = 0;
    int    words_sent = 0;
    int    words_checked = 0;
    longint cycle_count = 0;
    bit    quiet_idle = 1'b0;
    int    hold_off = 0;

    vector_math_unit_core u_top (.*);

    // Clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("FAIL vector_math_unit_core");
            $finish;
        end
    end

    // Fixed-point helpers of the predictor.
    function automatic longint sat32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint mulq(input longint a, input longint b);
        return (a * b) >>> FB;
    endfunction

    function automatic longint root_floor(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint dot4(input longint p[4], input longint q[4]);
        longint sum;
        sum = 0;
        for (int i = 0; i < 4; i++) sum += mulq(p[i], q[i]);
        return sat32(sum);
    endfunction

    // Computes the result vector and scalar of one word.
    function automatic t_res vector_result(input t_word w);
        longint a[4], b[4], r[4], p[4];
        longint s, so, one, nsq, nrm, k, alpha;
        int n;
        t_res res;
        s = w.s;
        so = 0;
        one = 64'sd1 << FB;
        n = four_comp ? 4 : 3;
        a = '{w.ax, w.ay, w.az, w.aw};
        b = '{w.bx, w.by, w.bz, w.bw};
        r = '{0, 0, 0, 0};
        p = '{0, 0, 0, 0};
        if (n == 3) begin
            a[3] = 0;
            b[3] = 0;
        end
        case (w.op)
            OP_FILL: for (int i = 0; i < n; i++) r[i] = s;
            OP_NEGATE: for (int i = 0; i < n; i++) r[i] = sat32(-a[i]);
            OP_ADD: for (int i = 0; i < n; i++) r[i] = sat32(a[i] + b[i]);
            OP_SUB: for (int i = 0; i < n; i++) r[i] = sat32(a[i] - b[i]);
            OP_SCALE: for (int i = 0; i < n; i++) r[i] = sat32(mulq(a[i], s));
            OP_CROSS: begin
                r[0] = sat32(mulq(a[1], b[2]) - mulq(a[2], b[1]));
                r[1] = sat32(mulq(a[2], b[0]) - mulq(a[0], b[2]));
                r[2] = sat32(mulq(a[0], b[1]) - mulq(a[1], b[0]));
            end
            OP_DOT: so = dot4(a, b);
            OP_NORMSQ: so = dot4(a, a);
            OP_NORM: so = root_floor(longint'(dot4(a, a)) << FB);
            OP_NORMALIZE: begin
                nsq = dot4(a, a);
                if (nsq > zero_thr) begin
                    nrm = root_floor(nsq << FB);
                    if (nrm > 0)
                        for (int i = 0; i < n; i++) r[i] = sat32((a[i] * one) / nrm);
                end
            end
            OP_PROJECT, OP_PLANE: begin
                nsq = dot4(b, b);
                if (nsq > zero_thr) begin
                    k = sat32((dot4(a, b) * one) / nsq);
                    for (int i = 0; i < n; i++) p[i] = sat32(mulq(b[i], k));
                end
                for (int i = 0; i < n; i++)
                    r[i] = (w.op == OP_PROJECT) ? p[i] : sat32(a[i] - p[i]);
            end
            OP_REFLECT: begin
                k = sat32(2 * dot4(a, b));
                for (int i = 0; i < n; i++) r[i] = sat32(a[i] - sat32(mulq(b[i], k)));
            end
            OP_LERP: begin
                alpha = sat32(one - s);
                for (int i = 0; i < n; i++)
                    r[i] = sat32(mulq(alpha, a[i]) + mulq(s, b[i]));
            end
            default: ;
        endcase
        res.rx = 32'(r[0]);
        res.ry = 32'(r[1]);
        res.rz = 32'(r[2]);
        res.rw = 32'(r[3]);
        res.so = 32'(so);
        return res;
    endfunction

    // Random idle decision, about 18 in a hundred unless in a quiet stretch.
    function automatic bit take_gap();
        return !quiet_idle && ($urandom_range(99) < 18);
    endfunction

    // Receiver side: random ready with an optional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !take_gap();
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $error("result word with no expectation waiting");
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                words_checked++;
                if (o_r_x !== want.rx) begin
                    $error("r_x expected %0d actual %0d", want.rx, o_r_x);
                    fail_count++;
                end
                if (o_r_y !== want.ry) begin
                    $error("r_y expected %0d actual %0d", want.ry, o_r_y);
                    fail_count++;
                end
                if (o_r_z !== want.rz) begin
                    $error("r_z expected %0d actual %0d", want.rz, o_r_z);
                    fail_count++;
                end
                if (o_r_w !== want.rw) begin
                    $error("r_w expected %0d actual %0d", want.rw, o_r_w);
                    fail_count++;
                end
                if (o_scalar_out !== want.so) begin
                    $error("scalar_out expected %0d actual %0d", want.so, o_scalar_out);
                    fail_count++;
                end
            end
        end
    end

    // Sends one word and waits for it to be accepted. Valid drops only in an
    // idle cycle or when the sender goes quiet.
    task automatic send_word(input t_word w);
        while (take_gap()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= w.op;
        i_a_x <= w.ax; i_a_y <= w.ay; i_a_z <= w.az; i_a_w <= w.aw;
        i_b_x <= w.bx; i_b_y <= w.by; i_b_z <= w.bz; i_b_w <= w.bw;
        i_scalar_in <= w.s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q.push_back(vector_result(w));
        words_sent++;
    endtask

    // Stops sending, waits until every expected result is in, then lets the
    // pipe drain.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // Writes one register while the block is idle.
    task automatic write_reg(input logic idx, input logic [15:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_USE_FOUR) four_comp = val[0];
        else zero_thr = val;
    endtask

    function automatic logic signed [31:0] rand_q(input int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(65536 * 8)) - 32'sd262144;
            2: return ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(2000)) - 32'sd1000;
        endcase
    endfunction

    function automatic t_word rand_word();
        t_word w;
        int m;
        m = $urandom_range(9);
        m = (m < 5) ? 1 : (m < 8) ? 0 : (m == 8) ? 2 : 3;
        w.op = 4'($urandom_range(15));
        w.ax = rand_q(m); w.ay = rand_q(m); w.az = rand_q(m); w.aw = rand_q(m);
        w.bx = rand_q(m); w.by = rand_q(m); w.bz = rand_q(m); w.bw = rand_q(m);
        w.s = ($urandom_range(3) == 0) ? rand_q(0) : rand_q(1);
        return w;
    endfunction

    // Every operation code with ordinary and extreme operands.
    task automatic test_directed();
        t_word w;
        for (int op = 0; op < 16; op++) begin
            w = '{op[3:0], 32'sh00010000, -32'sh00020000, 32'sh00008000, 32'sh00030000,
                  32'sh00000000, 32'sh00010000, -32'sh00010000, 32'sh00004000,
                  32'sh00008000};
            send_word(w);
        end
        w = '{OP_NEGATE, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
              0, 0, 0, 0, 0};
        send_word(w);
        w = '{OP_ADD, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh7FFFFFFF, 32'sh80000000, 1, 1, 32'sh7FFFFFFF};
        send_word(w);
        w = '{OP_NORMSQ, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0, 0, 0};
        send_word(w);
        w = '{OP_NORM, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0, 0, 0};
        send_word(w);
        // Tiny vectors fall under the near-zero threshold.
        w = '{OP_NORMALIZE, 1, 0, 0, 0, 0, 0, 0, 0, 0};
        send_word(w);
        w = '{OP_PROJECT, 32'sh00010000, 1, 0, 0, 256, 0, 0, 0, 0};
        send_word(w);
        w = '{OP_PLANE, 32'sh00010000, 5, 7, 0, 256, 0, 0, 0, 0};
        send_word(w);
        w = '{OP_REFLECT, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 32'sh7FFFFFFF, 1, 0, 0, 0};
        send_word(w);
        w = '{OP_LERP, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 32'sh80000000, 32'sh7FFFFFFF,
              0, 0, 32'sh80000000};
        send_word(w);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_word(rand_word());
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall input.
    task automatic test_backpressure();
        drain();
        hold_off = 200;
        quiet_idle = 1'b1;
        test_random(120);
        quiet_idle = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(100);
        write_reg(CFG_USE_FOUR, 16'd1);
        test_directed();
        test_random(100);
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        test_random(60);
        write_reg(CFG_THRESHOLD, 16'd0);
        test_backpressure();
        write_reg(CFG_USE_FOUR, 16'd0);
        write_reg(CFG_THRESHOLD, 16'd300);
        test_random(100);
        drain();
        $display("Covered all operation codes in three and four component modes,");
        $display("threshold settings 0, 1, 300 and 65535, %0d words checked of %0d sent.",
                 words_checked, words_sent);
        if (fail_count == 0) begin
            $display("PASS vector_math_unit_core");
        end else begin
            $display("FAIL vector_math_unit_core");
        end
        $finish;
    end
endmodule

FILE: vector_math_unit_core.f
design/vmu_pkg.sv
design/vmu_delay.sv
design/vmu_sqrt.sv
design/vmu_div.sv
design/vmu_front.sv
design/vector_math_unit_core.sv
bench/tb_vector_math_unit_core.sv
